// ----- design/sii_pkg.sv -----
// Shared constants, types and helpers for the bordered inverse insert block.
`default_nettype none
package sii_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int SUB_DIM   = MAX_DIM - 1;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = TERM_W + 4;
  localparam int DEN_W     = DATA_W + 2;
  localparam int DIV_W     = 2 * FRAC_BITS + 1;
  localparam int DIV_CW    = $clog2(DIV_W + 1);
  localparam int BLK_DEPTH = SUB_DIM * SUB_DIM;
  localparam int BLK_AW    = $clog2(BLK_DEPTH);
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int RES_DEPTH = MAX_DIM * MAX_DIM;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int DIM_W     = IDX_W + 1;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_AW-3:0] REG_MATRIX_SIZE = '0;
  localparam logic [DIM_W-1:0]  SIZE_RESET      = DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_COLUMN  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_UNUSED  = 2'd3
  } in_op_t;

  typedef enum logic [1:0] {A_BLK, A_PV, A_S, A_SB} a_sel_t;
  typedef enum logic {B_COL, B_PV} b_sel_t;
  typedef enum logic [1:0] {EK_DIAG, EK_NEG, EK_BLK} elem_kind_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_START, DP_ACC, DP_PV_WR, DP_DEN, DP_S, DP_SB_WR, DP_EL_WR, DP_RES_RD
  } dp_op_t;

  typedef struct packed {
    logic              blk_we;
    logic              blk_rd;
    logic [BLK_AW-1:0] blk_addr;
    logic              col_we;
    logic [IDX_W-1:0]  col_idx;
    logic [IDX_W-1:0]  pv_idx;
    logic [IDX_W-1:0]  sb_idx;
    logic              opnd_en;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    dp_op_t            op;
    elem_kind_t        kind;
    logic [RES_AW-1:0] res_addr;
  } sii_cmd_t;

  typedef struct packed {
    logic div_done;
  } sii_stat_t;

  // returns {overflow, saturated value}
  function automatic logic [DATA_W:0] sat_fn(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (x > hi) begin
      return {1'b1, hi[DATA_W-1:0]};
    end else if (x < lo) begin
      return {1'b1, lo[DATA_W-1:0]};
    end
    return {1'b0, x[DATA_W-1:0]};
  endfunction

endpackage
`default_nettype wire

// ----- design/sii_if.sv -----
// Request channel interfaces for input items and result items.
`default_nettype none
interface sii_in_if;
  import sii_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] value;
  logic [IDX_W-1:0]         insert_index;
  modport source (output valid, op, value, insert_index, input ready);
  modport sink (input valid, op, value, insert_index, output ready);
endinterface

interface sii_out_if;
  import sii_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     last;
  logic                     singular;
  modport source (output valid, out_value, out_row, out_col, last, singular, input ready);
  modport sink (input valid, out_value, out_row, out_col, last, singular, output ready);
endinterface
`default_nettype wire

// ----- design/sii_dp.sv -----
// Datapath: stores, shared multiplier, accumulator, divider and result buffer.
`default_nettype none
module sii_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sii_pkg::sii_cmd_t                 cmd,
  input  logic signed [sii_pkg::DATA_W-1:0] in_value,
  output sii_pkg::sii_stat_t                stat,
  output logic signed [sii_pkg::DATA_W-1:0] res_value,
  output logic                              singular
);
  import sii_pkg::*;

  logic signed [DATA_W-1:0] blk_mem [BLK_DEPTH];
  logic signed [DATA_W-1:0] res_mem [RES_DEPTH];
  logic signed [DATA_W-1:0] col_r [SUB_DIM];
  logic signed [DATA_W-1:0] pv_r [SUB_DIM];
  logic signed [DATA_W-1:0] sb_r [SUB_DIM];
  logic signed [DATA_W-1:0] blk_rd_r, res_rd_r, opa_r, opb_r, s_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DATA_W:0]          dmag_r, rem_r;
  logic [DIV_W-1:0]         quo_r;
  logic                     den_neg_r, den_zero_r, flag_r;
  logic [DIV_CW-1:0]        div_cnt_r;

  logic signed [DATA_W-1:0] a_mux, b_mux, sat_val;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_sum, sat_in, quo_ext;
  logic [DATA_W:0]          sat_res;
  logic                     sat_ovf;
  logic signed [DEN_W-1:0]  den_c;
  logic [DATA_W:0]          dmag_c;
  logic [DATA_W+1:0]        trial;
  logic [DATA_W+1:0]        diff;
  logic                     qbit;

  function automatic logic signed [ACC_W-1:0] sext(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  assign term    = prod_r[PROD_W-1:FRAC_BITS];
  assign acc_sum = acc_r + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
  assign quo_ext = den_neg_r ? -ACC_W'(quo_r) : ACC_W'(quo_r);

  always_comb begin
    unique case (cmd.a_sel)
      A_BLK:   a_mux = blk_rd_r;
      A_PV:    a_mux = pv_r[cmd.pv_idx];
      A_S:     a_mux = s_r;
      default: a_mux = sb_r[cmd.sb_idx];
    endcase
    unique case (cmd.b_sel)
      B_COL:   b_mux = col_r[cmd.col_idx];
      default: b_mux = pv_r[cmd.pv_idx];
    endcase
  end

  always_comb begin
    sat_in = acc_r;
    unique case (cmd.op)
      DP_S:     sat_in = quo_ext;
      DP_SB_WR: sat_in = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
      DP_EL_WR: begin
        unique case (cmd.kind)
          EK_DIAG: sat_in = sext(s_r);
          EK_NEG:  sat_in = -sext(opa_r);
          default: sat_in = sext(blk_rd_r) + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
        endcase
      end
      default:  sat_in = acc_r;
    endcase
    sat_res = sat_fn(sat_in);
    sat_ovf = sat_res[DATA_W];
    sat_val = sat_res[DATA_W-1:0];
  end

  assign den_c  = DEN_W'(1 << FRAC_BITS) - {{(DEN_W-DATA_W){sat_val[DATA_W-1]}}, sat_val};
  assign dmag_c = den_c[DEN_W-1] ? (DATA_W+1)'(0) - den_c[DATA_W:0] : den_c[DATA_W:0];
  assign trial  = {rem_r, quo_r[DIV_W-1]};
  assign diff   = trial - {1'b0, dmag_r};
  assign qbit   = (trial >= {1'b0, dmag_r});

  always_ff @(posedge clk) begin
    if (cmd.blk_we) begin
      blk_mem[cmd.blk_addr] <= in_value;
    end
    if (cmd.blk_rd) begin
      blk_rd_r <= blk_mem[cmd.blk_addr];
    end
    if (cmd.col_we) begin
      col_r[cmd.col_idx] <= in_value;
    end
    if (cmd.opnd_en) begin
      opa_r <= a_mux;
      opb_r <= b_mux;
    end
    if (cmd.mul_en) begin
      prod_r <= opa_r * opb_r;
    end
    unique case (cmd.op)
      DP_START: acc_r <= '0;
      DP_ACC:   acc_r <= acc_sum;
      DP_PV_WR: begin
        pv_r[cmd.pv_idx] <= sat_val;
        acc_r <= '0;
      end
      DP_DEN: begin
        acc_r      <= '0;
        dmag_r     <= dmag_c;
        den_neg_r  <= den_c[DEN_W-1];
        den_zero_r <= (den_c == '0);
        rem_r      <= '0;
        quo_r      <= {1'b1, {(DIV_W-1){1'b0}}};
      end
      DP_S:      s_r <= den_zero_r ? {1'b0, {(DATA_W-1){1'b1}}} : sat_val;
      DP_SB_WR:  sb_r[cmd.sb_idx] <= sat_val;
      DP_EL_WR:  res_mem[cmd.res_addr] <= sat_val;
      DP_RES_RD: res_rd_r <= res_mem[cmd.res_addr];
      default: begin
      end
    endcase
    if (cmd.op != DP_DEN && div_cnt_r != '0) begin
      rem_r <= qbit ? diff[DATA_W:0] : trial[DATA_W:0];
      quo_r <= {quo_r[DIV_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.op == DP_DEN) begin
        div_cnt_r <= DIV_CW'(DIV_W);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      unique case (cmd.op)
        DP_START: flag_r <= 1'b0;
        DP_PV_WR, DP_DEN, DP_SB_WR, DP_EL_WR: flag_r <= flag_r | sat_ovf;
        DP_S:     flag_r <= flag_r | den_zero_r | sat_ovf;
        default: begin
        end
      endcase
    end
  end

  assign stat.div_done = (div_cnt_r == '0);
  assign res_value     = res_rd_r;
  assign singular      = flag_r;

endmodule
`default_nettype wire

// ----- design/sii_ctrl.sv -----
// Controller: load counters and the compute and stream-out sequencer.
`default_nettype none
module sii_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sii_pkg::DIM_W-1:0]    dim,
  input  logic                         in_valid,
  input  logic [1:0]                   in_op,
  input  logic [sii_pkg::IDX_W-1:0]    in_insert_index,
  output logic                         in_ready,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [sii_pkg::IDX_W-1:0]    out_row,
  output logic [sii_pkg::IDX_W-1:0]    out_col,
  output logic                         out_last,
  output sii_pkg::sii_cmd_t            cmd,
  input  sii_pkg::sii_stat_t           stat
);
  import sii_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MV_RD, ST_MV_OP, ST_MV_MUL, ST_MV_ACC, ST_MV_WR,
    ST_QB_OP, ST_QB_MUL, ST_QB_ACC, ST_DEN, ST_DIV, ST_SDONE,
    ST_SB_OP, ST_SB_MUL, ST_SB_WR, ST_EL_RD, ST_EL_OP, ST_EL_MUL, ST_EL_WR,
    ST_EM_RD, ST_EM_SHOW
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  j_r, k_r, r_r, c_r, idx_r, col_cnt_r;
  logic [BLK_AW-1:0] addr_r, blk_cnt_r;
  logic [RES_AW-1:0] e_r;

  logic [IDX_W-1:0]  n, rr, cc, col_base, col_inc, col_next, idx_c, el_sb;
  logic [BLK_AW-1:0] nn, blk_base, blk_inc, blk_next;
  elem_kind_t        kind;
  in_op_t            op_c;
  logic              last_c;

  assign op_c     = in_op_t'(in_op);
  assign n        = IDX_W'(dim - 1'b1);
  assign nn       = BLK_AW'(n) * BLK_AW'(n);
  assign blk_base = (blk_cnt_r >= nn) ? '0 : blk_cnt_r;
  assign blk_inc  = blk_base + 1'b1;
  assign blk_next = (blk_inc >= nn) ? '0 : blk_inc;
  assign col_base = (col_cnt_r >= n) ? '0 : col_cnt_r;
  assign col_inc  = col_base + 1'b1;
  assign col_next = (col_inc >= n) ? '0 : col_inc;
  assign idx_c    = ({1'b0, in_insert_index} >= dim) ? n : in_insert_index;
  assign rr       = (r_r < idx_r) ? r_r : r_r - 1'b1;
  assign cc       = (c_r < idx_r) ? c_r : c_r - 1'b1;
  assign el_sb    = (r_r == idx_r) ? cc : rr;
  assign last_c   = (r_r == n) && (c_r == n);

  always_comb begin
    if (r_r == idx_r && c_r == idx_r) begin
      kind = EK_DIAG;
    end else if (r_r == idx_r || c_r == idx_r) begin
      kind = EK_NEG;
    end else begin
      kind = EK_BLK;
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_c)
            OP_BLOCK: begin
              cmd.blk_we   = 1'b1;
              cmd.blk_addr = blk_base;
            end
            OP_COLUMN: begin
              cmd.col_we  = 1'b1;
              cmd.col_idx = col_base;
            end
            OP_COMPUTE: cmd.op = DP_START;
            default: begin
            end
          endcase
        end
      end
      ST_MV_RD, ST_EL_RD: begin
        cmd.blk_rd   = 1'b1;
        cmd.blk_addr = addr_r;
      end
      ST_MV_OP: begin
        cmd.opnd_en = 1'b1;
        cmd.a_sel   = A_BLK;
        cmd.b_sel   = B_COL;
        cmd.col_idx = k_r;
      end
      ST_QB_OP: begin
        cmd.opnd_en = 1'b1;
        cmd.a_sel   = A_PV;
        cmd.pv_idx  = k_r;
        cmd.b_sel   = B_COL;
        cmd.col_idx = k_r;
      end
      ST_SB_OP: begin
        cmd.opnd_en = 1'b1;
        cmd.a_sel   = A_S;
        cmd.b_sel   = B_PV;
        cmd.pv_idx  = j_r;
      end
      ST_EL_OP: begin
        cmd.opnd_en = 1'b1;
        cmd.a_sel   = A_SB;
        cmd.sb_idx  = el_sb;
        cmd.b_sel   = B_PV;
        cmd.pv_idx  = cc;
      end
      ST_MV_MUL, ST_QB_MUL, ST_SB_MUL, ST_EL_MUL: cmd.mul_en = 1'b1;
      ST_MV_ACC, ST_QB_ACC: cmd.op = DP_ACC;
      ST_MV_WR: begin
        cmd.op     = DP_PV_WR;
        cmd.pv_idx = j_r;
      end
      ST_DEN:   cmd.op = DP_DEN;
      ST_SDONE: cmd.op = DP_S;
      ST_SB_WR: begin
        cmd.op     = DP_SB_WR;
        cmd.sb_idx = j_r;
      end
      ST_EL_WR: begin
        cmd.op       = DP_EL_WR;
        cmd.kind     = kind;
        cmd.res_addr = e_r;
      end
      ST_EM_RD: begin
        cmd.op       = DP_RES_RD;
        cmd.res_addr = e_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      j_r       <= '0;
      k_r       <= '0;
      r_r       <= '0;
      c_r       <= '0;
      e_r       <= '0;
      idx_r     <= '0;
      addr_r    <= '0;
      blk_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (op_c)
              OP_BLOCK:  blk_cnt_r <= blk_next;
              OP_COLUMN: col_cnt_r <= col_next;
              OP_COMPUTE: begin
                idx_r     <= idx_c;
                j_r       <= '0;
                k_r       <= '0;
                addr_r    <= '0;
                blk_cnt_r <= '0;
                col_cnt_r <= '0;
                state_r   <= ST_MV_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MV_RD:  state_r <= ST_MV_OP;
        ST_MV_OP:  state_r <= ST_MV_MUL;
        ST_MV_MUL: state_r <= ST_MV_ACC;
        ST_MV_ACC: begin
          addr_r <= addr_r + 1'b1;
          if (k_r == n - 1'b1) begin
            k_r     <= '0;
            state_r <= ST_MV_WR;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_MV_RD;
          end
        end
        ST_MV_WR: begin
          if (j_r == n - 1'b1) begin
            j_r     <= '0;
            state_r <= ST_QB_OP;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_MV_RD;
          end
        end
        ST_QB_OP:  state_r <= ST_QB_MUL;
        ST_QB_MUL: state_r <= ST_QB_ACC;
        ST_QB_ACC: begin
          if (k_r == n - 1'b1) begin
            k_r     <= '0;
            state_r <= ST_DEN;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_QB_OP;
          end
        end
        ST_DEN: state_r <= ST_DIV;
        ST_DIV: begin
          if (stat.div_done) begin
            state_r <= ST_SDONE;
          end
        end
        ST_SDONE:  state_r <= ST_SB_OP;
        ST_SB_OP:  state_r <= ST_SB_MUL;
        ST_SB_MUL: state_r <= ST_SB_WR;
        ST_SB_WR: begin
          if (j_r == n - 1'b1) begin
            j_r     <= '0;
            r_r     <= '0;
            c_r     <= '0;
            e_r     <= '0;
            addr_r  <= '0;
            state_r <= ST_EL_RD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_SB_OP;
          end
        end
        ST_EL_RD:  state_r <= ST_EL_OP;
        ST_EL_OP:  state_r <= ST_EL_MUL;
        ST_EL_MUL: state_r <= ST_EL_WR;
        ST_EL_WR: begin
          if (kind == EK_BLK) begin
            addr_r <= addr_r + 1'b1;
          end
          e_r <= e_r + 1'b1;
          if (c_r == n) begin
            c_r <= '0;
            if (r_r == n) begin
              r_r     <= '0;
              e_r     <= '0;
              state_r <= ST_EM_RD;
            end else begin
              r_r     <= r_r + 1'b1;
              state_r <= ST_EL_RD;
            end
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= ST_EL_RD;
          end
        end
        ST_EM_RD: state_r <= ST_EM_SHOW;
        ST_EM_SHOW: begin
          if (out_ready) begin
            if (last_c) begin
              r_r     <= '0;
              c_r     <= '0;
              e_r     <= '0;
              state_r <= ST_IDLE;
            end else begin
              e_r     <= e_r + 1'b1;
              state_r <= ST_EM_RD;
              if (c_r == n) begin
                c_r <= '0;
                r_r <= r_r + 1'b1;
              end else begin
                c_r <= c_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EM_SHOW);
  assign out_row   = r_r;
  assign out_col   = c_r;
  assign out_last  = last_c;

endmodule
`default_nettype wire

// ----- design/schur_inverse_insert.sv -----
// Top level: bordered inverse insert by Schur complement, with APB size register.
// Load requests (block or column element) and op 3 are taken while idle; op 3 is dropped.
// A compute request runs the sequencer up to the first result; that run is paced by the
// shared multiplier and the one-bit-per-cycle divider.
// Results then stream out, each held until taken; no new request is taken until the last is sent.
// Synchronous active-low reset clears the sequencer, load counts, flag and size (to 8).
`default_nettype none
module schur_inverse_insert (
  input  logic                        clk,
  input  logic                        rst_n,
  sii_in_if.sink                      in_chan,
  sii_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sii_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sii_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sii_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import sii_pkg::*;

  logic [DIM_W-1:0] size_r;
  logic [DIM_W-1:0] dim;
  sii_cmd_t         cmd;
  sii_stat_t        stat;
  logic             reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_MATRIX_SIZE);
  assign cfg_prdata = reg_hit ? CFG_DW'(size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      size_r <= cfg_pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    if (size_r < DIM_W'(2)) begin
      dim = DIM_W'(2);
    end else if (size_r > DIM_W'(MAX_DIM)) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = size_r;
    end
  end

  sii_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .dim             (dim),
    .in_valid        (in_chan.valid),
    .in_op           (in_chan.op),
    .in_insert_index (in_chan.insert_index),
    .in_ready        (in_chan.ready),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_row         (out_chan.out_row),
    .out_col         (out_chan.out_col),
    .out_last        (out_chan.last),
    .cmd             (cmd),
    .stat            (stat)
  );

  sii_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_chan.value),
    .stat      (stat),
    .res_value (out_chan.out_value),
    .singular  (out_chan.singular)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !in_chan.ready)
    else $error("result pending while input ready");

  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.last |-> out_chan.out_row == out_chan.out_col)
    else $error("last flag off the diagonal");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && out_chan.last |=> in_chan.ready && !out_chan.valid)
    else $error("not idle after final result");

endmodule
`default_nettype wire
